/* src/lkvc_pkg.sv */
`timescale 1ns / 1ps

package lkvc_pkg;

  localparam int unsigned CAPACITY_DEF = 16;

  localparam int unsigned CAP_W = 5;
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  localparam logic OP_GET = 1'b0;
  localparam logic OP_PUT = 1'b1;

  localparam logic REG_CAPACITY = 1'b0;

  localparam logic [31:0] MISS_VALUE = 32'hFFFF_FFFF;

  typedef enum logic [2:0] {
    REC_IDLE   = 3'b001,
    REC_TOUCH  = 3'b010,
    REC_INSERT = 3'b100
  } rec_op_t;

  typedef struct packed {
    rec_op_t op;
    logic    evict;
  } rec_cmd_t;

endpackage

/* src/lkvc_mem.sv */
`timescale 1ns / 1ps

module lkvc_mem #(
  parameter int unsigned CAPACITY = lkvc_pkg::CAPACITY_DEF,
  parameter int unsigned IW       = 4
) (
  input  logic          clk,
  input  logic          we,
  input  logic [IW-1:0] waddr,
  input  logic [31:0]   wkey,
  input  logic [31:0]   wvalue,
  input  logic [IW-1:0] raddr,
  output logic [31:0]   rkey,
  output logic [31:0]   rvalue
);

  logic [31:0] key_mem   [CAPACITY];
  logic [31:0] value_mem [CAPACITY];

  always_ff @(posedge clk) begin
    if (we) begin
      key_mem[waddr]   <= wkey;
      value_mem[waddr] <= wvalue;
    end
  end

  always_ff @(posedge clk) begin
    rkey   <= key_mem[raddr];
    rvalue <= value_mem[raddr];
  end

endmodule

/* src/lkvc_recency.sv */
`timescale 1ns / 1ps

module lkvc_recency #(
  parameter int unsigned CAPACITY = lkvc_pkg::CAPACITY_DEF,
  parameter int unsigned IW       = 4,
  parameter int unsigned RW       = 4,
  parameter int unsigned OW       = 5
) (
  input  logic               clk,
  input  logic               rst_n,
  input  lkvc_pkg::rec_cmd_t cmd,
  input  logic [IW-1:0]      slot,
  input  logic [IW-1:0]      evict_slot,
  input  logic [IW-1:0]      rd_idx,
  output logic               rd_valid,
  output logic [RW-1:0]      rd_rank,
  output logic [OW-1:0]      occupancy
);

  logic [CAPACITY-1:0] valid_r, valid_nxt, valid_ev;
  logic [RW-1:0]       rank_r   [CAPACITY];
  logic [RW-1:0]       rank_nxt [CAPACITY];
  logic [OW-1:0]       occ_r, occ_nxt;
  logic [RW-1:0]       touch_rank;

  assign touch_rank = rank_r[slot];
  assign rd_valid   = valid_r[rd_idx];
  assign rd_rank    = rank_r[rd_idx];
  assign occupancy  = occ_r;

  always_comb begin
    valid_nxt = valid_r;
    rank_nxt  = rank_r;
    occ_nxt   = occ_r;
    valid_ev  = valid_r;
    unique case (cmd.op)
      lkvc_pkg::REC_TOUCH: begin
        // age every entry newer than the touched one
        for (int i = 0; i < CAPACITY; i++) begin
          if (valid_r[i] && (rank_r[i] < touch_rank)) rank_nxt[i] = rank_r[i] + RW'(1);
        end
        rank_nxt[slot] = '0;
      end
      lkvc_pkg::REC_INSERT: begin
        if (cmd.evict) valid_ev[evict_slot] = 1'b0;
        for (int i = 0; i < CAPACITY; i++) begin
          if (valid_ev[i]) rank_nxt[i] = rank_r[i] + RW'(1);
        end
        if (cmd.evict) rank_nxt[evict_slot] = '0;
        valid_nxt       = valid_ev;
        valid_nxt[slot] = 1'b1;
        rank_nxt[slot]  = '0;
        occ_nxt         = cmd.evict ? occ_r : occ_r + OW'(1);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      occ_r   <= '0;
      for (int i = 0; i < CAPACITY; i++) rank_r[i] <= '0;
    end else begin
      valid_r <= valid_nxt;
      occ_r   <= occ_nxt;
      rank_r  <= rank_nxt;
    end
  end

  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    int'(occ_r) <= CAPACITY)
    else $error("occupancy above capacity");

  a_occ_count: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(valid_r) == int'(occ_r))
    else $error("occupancy does not match valid entries");

  a_insert_newest: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == lkvc_pkg::REC_INSERT) |=> (valid_r[$past(slot)] && rank_r[$past(slot)] == '0))
    else $error("inserted entry is not valid and most recent");

endmodule

/* src/lru_key_value_cache_top.sv */
`timescale 1ns / 1ps

// LRU key-value cache, CAPACITY entries (16 by default).
// One item at a time: in_ready stays low until the result is loaded into the output register.
// The key scan reads one slot per cycle through the single memory read port and comparator.
// Reset (rst_n, synchronous, active low): all entries invalid, occupancy zero,
//   capacity_in_use back to 16, sequencer idle, output empty.
module lru_key_value_cache_top #(
  parameter int unsigned CAPACITY = lkvc_pkg::CAPACITY_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  // input channel
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_op,
  input  logic signed [31:0] in_key,
  input  logic signed [31:0] in_value,
  // result channel
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_found,
  output logic signed [31:0] out_read_value,
  output logic               out_evicted,
  // configuration port
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [2:0]         cfg_paddr,
  input  logic [31:0]        cfg_pwdata,
  output logic [31:0]        cfg_prdata,
  output logic               cfg_pready
);

  localparam int unsigned IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned RW = IW;
  localparam int unsigned OW = $clog2(CAPACITY + 1);
  localparam int unsigned CW = (lkvc_pkg::CAP_W > OW + 1) ? lkvc_pkg::CAP_W : OW + 1;
  localparam logic [IW-1:0] LAST_SLOT = IW'(CAPACITY - 1);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_SCAN = 4'b0010,
    ST_UPD  = 4'b0100,
    ST_RESP = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  // configuration register
  logic [lkvc_pkg::CAP_W-1:0] cap_r;
  logic                       cfg_wr;

  // captured item
  logic        op_r;
  logic [31:0] key_r, val_r;

  // scan pipeline: issue address, then compare the registered read data
  logic [IW-1:0] scan_cnt_r, scan_cnt_nxt;
  logic          issue_r, issue_nxt;
  logic          cmp_v_r, cmp_v_nxt;
  logic [IW-1:0] cmp_idx_r;

  // scan findings
  logic          hit_r, hit_nxt;
  logic [IW-1:0] hit_idx_r, hit_idx_nxt;
  logic [31:0]   hitval_r, hitval_nxt;
  logic          free_r, free_nxt;
  logic [IW-1:0] free_idx_r, free_idx_nxt;
  logic          old_any_r, old_any_nxt;
  logic [IW-1:0] old_idx_r, old_idx_nxt;
  logic [RW-1:0] old_rank_r, old_rank_nxt;

  // pending result and output register
  logic        res_found_r, res_found_nxt;
  logic [31:0] res_value_r, res_value_nxt;
  logic        res_evict_r, res_evict_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        out_found_r;
  logic [31:0] out_value_r;
  logic        out_evicted_r;
  logic        out_load;

  // memory and recency interface
  logic               mem_we;
  logic [IW-1:0]      mem_waddr;
  logic [31:0]        rkey, rvalue;
  lkvc_pkg::rec_cmd_t rec_cmd;
  logic [IW-1:0]      rec_slot;
  logic               rd_valid;
  logic [RW-1:0]      rd_rank;
  logic [OW-1:0]      occupancy;

  // eviction decision
  logic [CW-1:0] cap_ext, eff_cap;
  logic          need_evict;
  logic [IW-1:0] ins_slot;
  logic          match;

  // ------------------------------------------------------------------
  // Configuration: write on the access phase, read back capacity.
  // ------------------------------------------------------------------
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= lkvc_pkg::CAP_RESET;
    end else if (cfg_wr && (cfg_paddr[2] == lkvc_pkg::REG_CAPACITY)) begin
      cap_r <= cfg_pwdata[lkvc_pkg::CAP_W-1:0];
    end
  end

  always_comb begin
    cfg_prdata = '0;
    if (cfg_paddr[2] == lkvc_pkg::REG_CAPACITY) begin
      cfg_prdata = {{(32 - lkvc_pkg::CAP_W){1'b0}}, cap_r};
    end
  end

  // Capacity zero acts as one; values above CAPACITY saturate.
  assign cap_ext    = CW'(cap_r);
  assign eff_cap    = (cap_r == '0) ? CW'(1) :
                      ((cap_ext > CW'(CAPACITY)) ? CW'(CAPACITY) : cap_ext);
  assign need_evict = (CW'(occupancy) + CW'(1)) > eff_cap;

  // Insert into the lowest invalid slot, counting the one freed by eviction.
  assign ins_slot = need_evict ?
                    ((free_r && (free_idx_r < old_idx_r)) ? free_idx_r : old_idx_r) :
                    free_idx_r;

  // Shared comparator: one stored key against the captured key per cycle.
  assign match = cmp_v_r && rd_valid && (rkey == key_r);

  assign in_ready = (state_r == ST_IDLE);
  assign out_load = (state_r == ST_RESP) && (!out_valid_r || out_ready);

  // ------------------------------------------------------------------
  // Sequencer
  // ------------------------------------------------------------------
  always_comb begin
    state_nxt     = state_r;
    scan_cnt_nxt  = scan_cnt_r;
    issue_nxt     = issue_r;
    cmp_v_nxt     = 1'b0;
    hit_nxt       = hit_r;
    hit_idx_nxt   = hit_idx_r;
    hitval_nxt    = hitval_r;
    free_nxt      = free_r;
    free_idx_nxt  = free_idx_r;
    old_any_nxt   = old_any_r;
    old_idx_nxt   = old_idx_r;
    old_rank_nxt  = old_rank_r;
    res_found_nxt = res_found_r;
    res_value_nxt = res_value_r;
    res_evict_nxt = res_evict_r;
    mem_we        = 1'b0;
    mem_waddr     = hit_idx_r;
    rec_cmd.op    = lkvc_pkg::REC_IDLE;
    rec_cmd.evict = 1'b0;
    rec_slot      = hit_idx_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          scan_cnt_nxt = '0;
          issue_nxt    = 1'b1;
          hit_nxt      = 1'b0;
          free_nxt     = 1'b0;
          old_any_nxt  = 1'b0;
          state_nxt    = ST_SCAN;
        end
      end
      ST_SCAN: begin
        // issue the next slot address
        if (issue_r) begin
          cmp_v_nxt = 1'b1;
          if (scan_cnt_r == LAST_SLOT) begin
            issue_nxt = 1'b0;
          end else begin
            scan_cnt_nxt = scan_cnt_r + IW'(1);
          end
        end
        // fold in the slot read last cycle
        if (cmp_v_r) begin
          if (match && !hit_r) begin
            hit_nxt     = 1'b1;
            hit_idx_nxt = cmp_idx_r;
            hitval_nxt  = rvalue;
          end
          if (!rd_valid && !free_r) begin
            free_nxt     = 1'b1;
            free_idx_nxt = cmp_idx_r;
          end
          if (rd_valid && (!old_any_r || (rd_rank > old_rank_r))) begin
            old_any_nxt  = 1'b1;
            old_idx_nxt  = cmp_idx_r;
            old_rank_nxt = rd_rank;
          end
          if (!issue_r) state_nxt = ST_UPD;
        end
      end
      ST_UPD: begin
        res_found_nxt = hit_r;
        res_evict_nxt = 1'b0;
        res_value_nxt = '0;
        if (op_r == lkvc_pkg::OP_GET) begin
          res_value_nxt = hit_r ? hitval_r : lkvc_pkg::MISS_VALUE;
          if (hit_r) rec_cmd.op = lkvc_pkg::REC_TOUCH;
        end else if (hit_r) begin
          mem_we     = 1'b1;
          rec_cmd.op = lkvc_pkg::REC_TOUCH;
        end else begin
          mem_we        = 1'b1;
          mem_waddr     = ins_slot;
          rec_slot      = ins_slot;
          rec_cmd.op    = lkvc_pkg::REC_INSERT;
          rec_cmd.evict = need_evict;
          res_evict_nxt = need_evict;
        end
        state_nxt = ST_RESP;
      end
      ST_RESP: begin
        // hold until the output register can take the result
        if (out_load) state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;
    if (out_load) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      issue_r     <= 1'b0;
      cmp_v_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      issue_r     <= issue_nxt;
      cmp_v_r     <= cmp_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload and scan datapath registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op_r  <= in_op;
      key_r <= in_key;
      val_r <= in_value;
    end
    scan_cnt_r  <= scan_cnt_nxt;
    cmp_idx_r   <= scan_cnt_r;
    hit_r       <= hit_nxt;
    hit_idx_r   <= hit_idx_nxt;
    hitval_r    <= hitval_nxt;
    free_r      <= free_nxt;
    free_idx_r  <= free_idx_nxt;
    old_any_r   <= old_any_nxt;
    old_idx_r   <= old_idx_nxt;
    old_rank_r  <= old_rank_nxt;
    res_found_r <= res_found_nxt;
    res_value_r <= res_value_nxt;
    res_evict_r <= res_evict_nxt;
    if (out_load) begin
      out_found_r   <= res_found_r;
      out_value_r   <= res_value_r;
      out_evicted_r <= res_evict_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_found      = out_found_r;
  assign out_read_value = out_value_r;
  assign out_evicted    = out_evicted_r;

  // ------------------------------------------------------------------
  // Storage
  // ------------------------------------------------------------------
  lkvc_mem #(
    .CAPACITY (CAPACITY),
    .IW       (IW)
  ) u_mem (
    .clk    (clk),
    .we     (mem_we),
    .waddr  (mem_waddr),
    .wkey   (key_r),
    .wvalue (val_r),
    .raddr  (scan_cnt_r),
    .rkey   (rkey),
    .rvalue (rvalue)
  );

  lkvc_recency #(
    .CAPACITY (CAPACITY),
    .IW       (IW),
    .RW       (RW),
    .OW       (OW)
  ) u_recency (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (rec_cmd),
    .slot       (rec_slot),
    .evict_slot (old_idx_r),
    .rd_idx     (cmp_idx_r),
    .rd_valid   (rd_valid),
    .rd_rank    (rd_rank),
    .occupancy  (occupancy)
  );

  // ------------------------------------------------------------------
  // Assertions
  // ------------------------------------------------------------------
  a_evict_on_miss: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_evicted_r) |-> !out_found_r)
    else $error("eviction reported on a hit");

  a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken while an item is in flight");

  a_slot_available: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_UPD) |-> (hit_r || free_r || need_evict))
    else $error("no slot for insertion");

  a_evict_has_victim: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_UPD && need_evict) |-> old_any_r)
    else $error("eviction with no valid entry");

endmodule
